// File: design/ata_pio_command_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer_defines
// Assertion macros used by the sequencer's controller RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_COMMAND_SEQUENCER_DEFINES_SVH
`define ATA_PIO_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ATAPIO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("atapio: assertion failed");
`define ATAPIO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    `ATAPIO_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define ATAPIO_ASSERT(lbl, clk, rst_n, prop)
`define ATAPIO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/atapio_pkg.sv
// ----------------------------------------------------------------------------
// atapio_pkg
// Types, codes and constants of the ATA PIO LBA28 command sequencer.
// ----------------------------------------------------------------------------
package atapio_pkg;

    // input commands
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_DONE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_REG_WR   = 2'd0;
    localparam logic [1:0] KIND_DATA_RDY = 2'd1;
    localparam logic [1:0] KIND_XFER_END = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_DRQ  = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_RANGE   = 2'd3;

    // task-file register offsets
    localparam logic [2:0] TF_SECT_CNT = 3'd2;
    localparam logic [2:0] TF_LBA_LO   = 3'd3;
    localparam logic [2:0] TF_LBA_MID  = 3'd4;
    localparam logic [2:0] TF_LBA_HI   = 3'd5;
    localparam logic [2:0] TF_DEVICE   = 3'd6;
    localparam logic [2:0] TF_COMMAND  = 3'd7;

    localparam logic [7:0] DEV_BASE     = 8'hE0;  // obsolete bits plus LBA mode
    localparam logic [7:0] DEV_SLAVE    = 8'h10;
    localparam logic [7:0] ATA_RD_SECT  = 8'h20;
    localparam logic [7:0] ATA_WR_SECT  = 8'h30;
    localparam int         ST_BSY_BIT   = 7;
    localparam int         ST_DRQ_BIT   = 3;

    localparam int         MAX_CHUNK    = 256;
    localparam int         MAX_RESULTS  = 7;
    localparam int         CHUNK_W      = 9;

    // configuration registers
    localparam logic       CFG_MAX_LBA       = 1'b0;
    localparam logic       CFG_TIMEOUT       = 1'b1;
    localparam logic [27:0] MAX_LBA_RST      = 28'd163839;
    localparam logic [11:0] TIMEOUT_RST      = 12'd3000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [1:0]  command;
        logic        direction;
        logic        drive;
        logic [27:0] lba;
        logic [28:0] count;
        logic [7:0]  status;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_offset;
        logic [7:0]  reg_value;
        logic [16:0] word_count;
        logic [1:0]  error_code;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_slot_t;

    typedef struct packed {
        logic                         load;
        logic [2:0]                   cnt;
        out_item_t [MAX_RESULTS-1:0]  ent;
    } plan_t;

    typedef struct packed {
        logic [27:0] max_lba;
        logic [11:0] timeout_ticks;
    } cfg_t;

endpackage

// File: design/ata_pio_command_sequencer.sv
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer
// ATA PIO LBA28 sector transfer sequencer: task-file writes, status and timeout.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ channel (start, status sample, timer tick,
// chunk data done) and each causes zero to seven results on the m_ channel,
// the final one of a run flagged by last. Results are task-file register
// writes, data-ready notices with the chunk word count, transfer end, or errors.
// An item is held in the input register until the controller takes it, then its
// results are planned into the result bank and presented on the m_ channel from
// there. Results leave one per cycle while m_ready is high.
// Throughput: one item per cycle into the input register while s_ready is high;
// an item with results holds the result bank until its last result has gone, so a
// start item that issues a chunk occupies the m_ channel for its seven results.
// Items without results pass even while the bank drains.
// A stall on m_ready freezes the bank; the input register then fills and
// s_ready drops until the bank's last result has gone.
// Reset clears the transfer state to idle and loads the register defaults
// (max_lba 163839, timeout_ticks 3000). Registers live on the APB port at
// byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module ata_pio_command_sequencer import atapio_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t     cfg;
    in_slot_t slot;
    plan_t    plan;
    logic     take;
    logic     q_free;

    atapio_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atapio_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (take),
        .slot    (slot)
    );

    atapio_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .slot    (slot),
        .cfg     (cfg),
        .q_free  (q_free),
        .take    (take),
        .plan    (plan)
    );

    atapio_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .plan    (plan),
        .q_free  (q_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: design/atapio_cfg.sv
// ----------------------------------------------------------------------------
// atapio_cfg
// APB register file holding the address limit and the busy timeout.
// ----------------------------------------------------------------------------
module atapio_cfg import atapio_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [27:0] max_lba_reg;
    logic [11:0] timeout_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lba_reg <= MAX_LBA_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (wr_en) begin
            if (paddr[2] == CFG_MAX_LBA) begin
                max_lba_reg <= pwdata[27:0];
            end else begin
                timeout_reg <= pwdata[11:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_MAX_LBA) begin
            prdata = {4'b0, max_lba_reg};
        end else begin
            prdata = {20'b0, timeout_reg};
        end
    end

    assign cfg.max_lba       = max_lba_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

// File: design/atapio_in_reg.sv
// ----------------------------------------------------------------------------
// atapio_in_reg
// Input holding register; takes a new item when empty or when the held one moves on.
// ----------------------------------------------------------------------------
module atapio_in_reg import atapio_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     take,
    output in_slot_t slot
);

    logic     valid_reg;
    in_item_t item_reg;

    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

// File: design/atapio_ctrl.sv
// ----------------------------------------------------------------------------
// atapio_ctrl
// Transfer state and result planning: one item in, up to seven results out.
// ----------------------------------------------------------------------------
`include "ata_pio_command_sequencer_defines.svh"

module atapio_ctrl import atapio_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  in_slot_t slot,
    input  cfg_t     cfg,
    input  logic     q_free,
    output logic     take,
    output plan_t    plan
);

    // addr_reg is the current chunk's start, remain_reg the sectors not yet done
    phase_t              phase_reg, phase_next;
    logic [28:0]         addr_reg, addr_next;
    logic [28:0]         remain_reg, remain_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic                is_write_reg, is_write_next;
    logic                slave_reg, slave_next;
    logic [11:0]         wait_reg, wait_next;

    in_item_t            item;
    logic [28:0]         addr_d, remain_d, chunk_addr, chunk_remain;
    logic [CHUNK_W-1:0]  new_chunk;
    logic [11:0]         wait_inc;
    logic                range_err;
    logic                issue, emit_dev, emit_chunk, emit_dready, emit_done, emit_err;
    logic [1:0]          err_code;
    logic                single;
    logic [2:0]          n_res;
    logic [7:0]          dev_bits;
    logic                active_ok;
    out_item_t [MAX_RESULTS-1:0] tail;

    function automatic out_item_t mk(input logic [1:0] kind, input logic [2:0] off,
                                     input logic [7:0] val, input logic [16:0] words,
                                     input logic [1:0] err);
        out_item_t r;
        r.kind       = kind;
        r.reg_offset = off;
        r.reg_value  = val;
        r.word_count = words;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    assign item     = slot.item;
    assign addr_d   = addr_reg + {20'b0, chunk_reg};
    assign remain_d = remain_reg - {20'b0, chunk_reg};
    assign wait_inc = (wait_reg == '1) ? wait_reg : wait_reg + 12'd1;

    assign chunk_addr   = (item.command == CMD_START) ? {1'b0, item.lba} : addr_d;
    assign chunk_remain = (item.command == CMD_START) ? item.count : remain_d;
    assign range_err    = chunk_addr > {1'b0, cfg.max_lba};
    assign new_chunk    = (chunk_remain < 29'(MAX_CHUNK)) ? chunk_remain[CHUNK_W-1:0]
                                                          : CHUNK_W'(MAX_CHUNK);

    // next state and which results this item causes
    always_comb begin
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        remain_next   = remain_reg;
        chunk_next    = chunk_reg;
        is_write_next = is_write_reg;
        slave_next    = slave_reg;
        wait_next     = wait_reg;
        issue         = 1'b0;
        emit_dev      = 1'b0;
        emit_chunk    = 1'b0;
        emit_dready   = 1'b0;
        emit_done     = 1'b0;
        emit_err      = 1'b0;
        err_code      = ERR_NONE;
        unique case (item.command)
            CMD_START: begin
                emit_dev      = 1'b1;
                is_write_next = item.direction;
                slave_next    = item.drive;
                addr_next     = {1'b0, item.lba};
                remain_next   = item.count;
                chunk_next    = '0;
                wait_next     = '0;
                phase_next    = PH_IDLE;
                if (item.count == '0) begin
                    emit_done = 1'b1;
                end else begin
                    issue = 1'b1;
                end
            end
            CMD_STATUS: begin
                if (phase_reg == PH_WAIT && !item.status[ST_BSY_BIT]) begin
                    if (item.status[ST_DRQ_BIT]) begin
                        emit_dready = 1'b1;
                        phase_next  = PH_DATA;
                    end else begin
                        emit_err   = 1'b1;
                        err_code   = ERR_NO_DRQ;
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_TICK: begin
                if (phase_reg == PH_WAIT) begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.timeout_ticks) begin
                        emit_err   = 1'b1;
                        err_code   = ERR_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_DONE: begin
                if (phase_reg == PH_DATA) begin
                    addr_next   = addr_d;
                    remain_next = remain_d;
                    if (remain_d == '0) begin
                        emit_done  = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        issue = 1'b1;
                    end
                end
            end
        endcase
        if (issue) begin
            if (range_err) begin
                emit_err   = 1'b1;
                err_code   = ERR_RANGE;
                phase_next = PH_IDLE;
            end else begin
                emit_chunk = 1'b1;
                chunk_next = new_chunk;
                wait_next  = '0;
                phase_next = PH_WAIT;
            end
        end
    end

    // result list for the planned run
    always_comb begin
        dev_bits = DEV_BASE | (slave_next ? DEV_SLAVE : 8'h00);
        single   = emit_dready || emit_done || emit_err;
        n_res    = {2'b0, emit_dev} + (emit_chunk ? 3'd6 : {2'b0, single});
        tail     = '0;
        if (emit_chunk) begin
            tail[0] = mk(KIND_REG_WR, TF_SECT_CNT, new_chunk[7:0], '0, ERR_NONE);
            tail[1] = mk(KIND_REG_WR, TF_LBA_LO, chunk_addr[7:0], '0, ERR_NONE);
            tail[2] = mk(KIND_REG_WR, TF_LBA_MID, chunk_addr[15:8], '0, ERR_NONE);
            tail[3] = mk(KIND_REG_WR, TF_LBA_HI, chunk_addr[23:16], '0, ERR_NONE);
            tail[4] = mk(KIND_REG_WR, TF_DEVICE, dev_bits | {4'b0, chunk_addr[27:24]},
                         '0, ERR_NONE);
            tail[5] = mk(KIND_REG_WR, TF_COMMAND, is_write_next ? ATA_WR_SECT : ATA_RD_SECT,
                         '0, ERR_NONE);
        end else if (emit_dready) begin
            tail[0] = mk(KIND_DATA_RDY, '0, '0, {chunk_reg, 8'b0}, ERR_NONE);
        end else if (emit_done) begin
            tail[0] = mk(KIND_XFER_END, '0, '0, '0, ERR_NONE);
        end else if (emit_err) begin
            tail[0] = mk(KIND_ERROR, '0, '0, '0, err_code);
        end
        plan.ent[0] = emit_dev ? mk(KIND_REG_WR, TF_DEVICE, dev_bits, '0, ERR_NONE) : tail[0];
        for (int i = 1; i < MAX_RESULTS; i++) begin
            plan.ent[i] = emit_dev ? tail[i-1] : tail[i];
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            plan.ent[i].last = (3'(i) == n_res - 3'd1);
        end
        plan.cnt  = n_res;
        take      = slot.valid && (n_res == '0 || q_free);
        plan.load = take && (n_res != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            addr_reg     <= '0;
            remain_reg   <= '0;
            chunk_reg    <= '0;
            is_write_reg <= 1'b0;
            slave_reg    <= 1'b0;
            wait_reg     <= '0;
        end else if (take) begin
            phase_reg    <= phase_next;
            addr_reg     <= addr_next;
            remain_reg   <= remain_next;
            chunk_reg    <= chunk_next;
            is_write_reg <= is_write_next;
            slave_reg    <= slave_next;
            wait_reg     <= wait_next;
        end
    end

    assign active_ok = (chunk_reg != '0) && (remain_reg >= {20'b0, chunk_reg});

    `ATAPIO_ASSERT_IMPL(a_load_needs_room, aclk, aresetn, plan.load, q_free)
    `ATAPIO_ASSERT_IMPL(a_no_stall_when_free, aclk, aresetn, slot.valid && q_free, take)
    `ATAPIO_ASSERT_IMPL(a_active_has_chunk, aclk, aresetn, phase_reg != PH_IDLE, active_ok)

endmodule

// File: design/atapio_out_queue.sv
// ----------------------------------------------------------------------------
// atapio_out_queue
// Result register bank; shifts out one planned result per transfer.
// ----------------------------------------------------------------------------
module atapio_out_queue import atapio_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  plan_t     plan,
    output logic      q_free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    out_item_t [MAX_RESULTS-1:0] ent_reg;
    logic [2:0]                  cnt_reg;
    logic                        xfer;

    assign m_valid = (cnt_reg != '0);
    assign m_data  = ent_reg[0];
    assign xfer    = m_valid && m_ready;
    // free when empty or once the final result of the run leaves
    assign q_free  = (cnt_reg == '0) || (xfer && cnt_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (plan.load) begin
            cnt_reg <= plan.cnt;
        end else if (xfer) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (plan.load) begin
            ent_reg <= plan.ent;
        end else if (xfer) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                ent_reg[i] <= ent_reg[i+1];
            end
            ent_reg[MAX_RESULTS-1] <= '0;
        end
    end

endmodule
